@@ rtl/core/upwind_slope_xy_stencil_macros.svh @@
// Assertion macros for the upwind slope stencil checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef UPWIND_SLOPE_XY_STENCIL_MACROS_SVH
`define UPWIND_SLOPE_XY_STENCIL_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define UPSXY_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("upsxy: same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define UPSXY_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("upsxy: next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define UPSXY_ASSERT_RESET(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("upsxy: reset check failed");

`endif

@@ rtl/core/upsxy_pkg.sv @@
// Shared constants and types for the upwind slope stencil.
// No dependencies; imported by the slope pipeline and the top level.
package upsxy_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int ELEV_BITS  = 24;
  localparam int SLOPE_BITS = 32;

  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = 16;
  localparam int GW_BITS      = 11;
  localparam int GH_BITS      = 16;
  localparam int INV_BITS     = 24;
  localparam int CFG_BITS     = 24;
  localparam int CFG_IDX_BITS = 2;

  // Elevation difference, product of difference and Q8.16 reciprocal
  localparam int DIFF_BITS  = ELEV_BITS + 1;
  localparam int PROD_BITS  = DIFF_BITS + INV_BITS + 1;
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_BITS = PROD_BITS + 1;
  localparam int Q_BITS     = ROUND_BITS - FRAC_BITS;
  localparam int EXT_BITS   = (Q_BITS > SLOPE_BITS) ? Q_BITS : SLOPE_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_WIDTH    = 2'd0,
    REG_GRID_HEIGHT   = 2'd1,
    REG_INV_SPACING_X = 2'd2,
    REG_INV_SPACING_Y = 2'd3
  } cfg_reg_t;

  // One axis: back difference d1, forward difference d2.
  // A one-sided slope uses d2 alone.
  typedef struct packed {
    logic [DIFF_BITS-1:0] d1;
    logic [DIFF_BITS-1:0] d2;
    logic                 one_sided;
  } diff_t;

  typedef struct packed {
    logic [COL_BITS-1:0] col;
    logic [ROW_BITS-1:0] row;
    logic                last;
    logic                eof;
  } meta_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    meta_t meta;
  } slope_req_t;

endpackage

@@ rtl/core/upwind_slope_xy_stencil.sv @@
// Upwind x/y terrain slope stencil over a raster stream of elevations.
// Channels: elev_valid/elev_stall carry one elevation item per accepted edge,
//   slope_valid/slope_stall carry one result (slopes, cell position, flags).
//   cfg_write/cfg_index/cfg_data set geometry and reciprocal spacings; write
//   them only while idle. A geometry write restarts the frame at cell (0, 0).
// Results lag one row: rows 1 to height-1 each give the cell above them.
//   Last-row items also flush their own row: one to three results each, and
//   last_of_item marks the final one; end_of_frame marks cell
//   (width-1, height-1).
// Path: a result leaves the output register once its item has passed the
//   job register, operand stage, multiply, select and round.
// Throughput: one item per cycle outside the last row unless slope_stall
//   holds the pipeline; a last-row item waits until all its results are sent,
//   one result per cycle. The row stores are two 1-read/1-write memories with a
//   registered read, addressed one item ahead from the next column count.
// Stall: slope_stall holds the output register and backs up through the
//   pipeline; elev_stall rises once the job register cannot drain.
// Reset: clears counters, store select, pipeline valids and the registers
//   to their defaults. Row store contents need no clearing.
module upwind_slope_xy_stencil (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [upsxy_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [upsxy_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                   elev_valid,
  output logic                                   elev_stall,
  input  logic signed [upsxy_pkg::ELEV_BITS-1:0] elevation,
  output logic                                   slope_valid,
  input  logic                                   slope_stall,
  output logic signed [upsxy_pkg::SLOPE_BITS-1:0] slope_x,
  output logic signed [upsxy_pkg::SLOPE_BITS-1:0] slope_y,
  output logic [upsxy_pkg::COL_BITS-1:0]         cell_column,
  output logic [upsxy_pkg::ROW_BITS-1:0]         cell_row,
  output logic                                   last_of_item,
  output logic                                   end_of_frame
);
  import upsxy_pkg::*;

  localparam logic [GW_BITS-1:0]  GW_RESET  = GW_BITS'(1024);
  localparam logic [GH_BITS-1:0]  GH_RESET  = GH_BITS'(1024);
  localparam logic [INV_BITS-1:0] INV_RESET = INV_BITS'(65536);

  // Result slots of one item, in emission order
  localparam int R_MAIN   = 0;
  localparam int R_TAIL   = 1;
  localparam int R_CORNER = 2;

  typedef struct packed {
    logic [ELEV_BITS-1:0] a;
    logic [ELEV_BITS-1:0] b;
    logic [ELEV_BITS-1:0] nxt;
    logic [ELEV_BITS-1:0] old;
    logic [ELEV_BITS-1:0] e;
    logic [ELEV_BITS-1:0] p0;
    logic [ELEV_BITS-1:0] p1;
    logic [COL_BITS-1:0]  col;
    logic [ROW_BITS-1:0]  row;
    logic                 at_c0;
    logic                 at_c1;
    logic                 at_end;
    logic                 at_r1;
  } job_t;

  function automatic logic [DIFF_BITS-1:0] dif(
    input logic [ELEV_BITS-1:0] hi,
    input logic [ELEV_BITS-1:0] lo
  );
    logic signed [DIFF_BITS-1:0] h;
    logic signed [DIFF_BITS-1:0] l;
    h = DIFF_BITS'($signed(hi));
    l = DIFF_BITS'($signed(lo));
    return h - l;
  endfunction

  // Configuration registers
  logic [GW_BITS-1:0]  grid_width;
  logic [GH_BITS-1:0]  grid_height;
  logic [INV_BITS-1:0] inv_spacing_x;
  logic [INV_BITS-1:0] inv_spacing_y;
  logic                geom_write;

  assign geom_write = cfg_write && (cfg_reg_t'(cfg_index) == REG_GRID_WIDTH ||
                                    cfg_reg_t'(cfg_index) == REG_GRID_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= GW_RESET;
      grid_height   <= GH_RESET;
      inv_spacing_x <= INV_RESET;
      inv_spacing_y <= INV_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:    grid_width    <= cfg_data[GW_BITS-1:0];
        REG_GRID_HEIGHT:   grid_height   <= cfg_data[GH_BITS-1:0];
        REG_INV_SPACING_X: inv_spacing_x <= cfg_data[INV_BITS-1:0];
        REG_INV_SPACING_Y: inv_spacing_y <= cfg_data[INV_BITS-1:0];
      endcase
    end
  end

  // Clamped geometry as last column / last row index
  logic [COL_BITS-1:0] col_last;
  logic [ROW_BITS-1:0] row_last;

  always_comb begin
    priority if (grid_width < GW_BITS'(2))    col_last = COL_BITS'(1);
    else if (32'(grid_width) > 32'(MAX_WIDTH)) col_last = COL_BITS'(MAX_WIDTH - 1);
    else                                       col_last = COL_BITS'(grid_width - GW_BITS'(1));
    if (grid_height < GH_BITS'(2)) row_last = ROW_BITS'(1);
    else                           row_last = ROW_BITS'(grid_height - GH_BITS'(1));
  end

  // Position and store select
  logic [COL_BITS-1:0] col, col_next;
  logic [ROW_BITS-1:0] row, row_next;
  logic                sel, sel_next;
  logic                acc;

  always_comb begin
    col_next = col;
    row_next = row;
    sel_next = sel;
    priority if (geom_write) begin
      col_next = '0;
      row_next = '0;
    end else if (acc) begin
      if (col == col_last) begin
        col_next = '0;
        sel_next = ~sel;
        row_next = (row == row_last) ? '0 : row + ROW_BITS'(1);
      end else begin
        col_next = col + COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      sel <= 1'b0;
    end else begin
      col <= col_next;
      row <= row_next;
      sel <= sel_next;
    end
  end

  // Row stores. sel=0: A holds the previous row, B the row before it.
  // The store holding the older row takes the incoming sample at its column.
  logic [ELEV_BITS-1:0] row_store_a [MAX_WIDTH];
  logic [ELEV_BITS-1:0] row_store_b [MAX_WIDTH];
  logic [COL_BITS-1:0]  raddr_a, raddr_b;
  logic                 wen_a, wen_b;
  logic [ELEV_BITS-1:0] rd_a, rd_b, wr_data;
  logic                 fwd_a, fwd_b;
  logic [ELEV_BITS-1:0] mem_a_q, mem_b_q, nxt_q, old_q;

  // Read ahead for the next item: previous row at column+1, older row at column
  assign raddr_a = sel_next ? col_next : col_next + COL_BITS'(1);
  assign raddr_b = sel_next ? col_next + COL_BITS'(1) : col_next;
  assign wen_a   = acc && sel;
  assign wen_b   = acc && !sel;

  always_ff @(posedge clk) begin
    if (wen_a) row_store_a[col] <= elevation;
    if (wen_b) row_store_b[col] <= elevation;
    rd_a    <= row_store_a[raddr_a];
    rd_b    <= row_store_b[raddr_b];
    wr_data <= elevation;
  end

  // A read that meets a write to the same entry sees the written sample
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_a <= 1'b0;
      fwd_b <= 1'b0;
    end else begin
      fwd_a <= wen_a && (raddr_a == col);
      fwd_b <= wen_b && (raddr_b == col);
    end
  end

  assign mem_a_q = fwd_a ? wr_data : rd_a;
  assign mem_b_q = fwd_b ? wr_data : rd_b;
  assign nxt_q   = sel ? mem_b_q : mem_a_q;
  assign old_q   = sel ? mem_a_q : mem_b_q;

  // Taps along the previous row and the current row
  logic [ELEV_BITS-1:0] a_tap, b_tap, first_elev, p0, p1;

  always_ff @(posedge clk) begin
    if (acc) begin
      a_tap <= b_tap;
      b_tap <= (col == col_last) ? first_elev : nxt_q;
      p1    <= p0;
      p0    <= elevation;
      if (col == '0) first_elev <= elevation;
    end
  end

  // Job register: one item and the results it still owes
  job_t       job;
  logic [2:0] pend, pick, pend_left, pend_new;
  logic       req_ready, emit, job_free;
  slope_req_t req;

  assign pick[R_MAIN]   = pend[R_MAIN];
  assign pick[R_TAIL]   = !pend[R_MAIN] && pend[R_TAIL];
  assign pick[R_CORNER] = !pend[R_MAIN] && !pend[R_TAIL] && pend[R_CORNER];
  assign pend_left      = pend & ~pick;
  assign emit           = (|pend) && req_ready;
  assign job_free       = !(|pend) || (emit && !(|pend_left));
  assign elev_stall     = !job_free;
  assign acc            = elev_valid && job_free;

  assign pend_new[R_MAIN]   = (row != '0);
  assign pend_new[R_TAIL]   = (row == row_last) && (col != '0);
  assign pend_new[R_CORNER] = (row == row_last) && (col == col_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (acc) begin
      pend <= pend_new;
    end else if (emit) begin
      pend <= pend_left;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      job.a      <= a_tap;
      job.b      <= b_tap;
      job.nxt    <= nxt_q;
      job.old    <= old_q;
      job.e      <= elevation;
      job.p0     <= p0;
      job.p1     <= p1;
      job.col    <= col;
      job.row    <= row;
      job.at_c0  <= (col == '0);
      job.at_c1  <= (col == COL_BITS'(1));
      job.at_end <= (col == col_last);
      job.at_r1  <= (row == ROW_BITS'(1));
    end
  end

  // Operands of the result being sent
  always_comb begin
    priority if (pick[R_MAIN]) begin
      // cell (c, r-1)
      req.x.d1        = dif(job.b, job.a);
      req.x.d2        = job.at_end ? dif(job.b, job.a) : dif(job.nxt, job.b);
      req.x.one_sided = job.at_c0 || job.at_end;
      req.y.d1        = dif(job.b, job.old);
      req.y.d2        = dif(job.e, job.b);
      req.y.one_sided = job.at_r1;
      req.meta.col    = job.col;
      req.meta.row    = job.row - ROW_BITS'(1);
      req.meta.last   = !pend[R_TAIL] && !pend[R_CORNER];
      req.meta.eof    = 1'b0;
    end else if (pick[R_TAIL]) begin
      // cell (c-1, r) on the last row
      req.x.d1        = dif(job.p0, job.p1);
      req.x.d2        = dif(job.e, job.p0);
      req.x.one_sided = job.at_c1;
      req.y.d1        = dif(job.p0, job.a);
      req.y.d2        = dif(job.p0, job.a);
      req.y.one_sided = 1'b1;
      req.meta.col    = job.col - COL_BITS'(1);
      req.meta.row    = job.row;
      req.meta.last   = !pend[R_CORNER];
      req.meta.eof    = 1'b0;
    end else begin
      // last cell of the frame
      req.x.d1        = dif(job.e, job.p0);
      req.x.d2        = dif(job.e, job.p0);
      req.x.one_sided = 1'b1;
      req.y.d1        = dif(job.e, job.b);
      req.y.d2        = dif(job.e, job.b);
      req.y.one_sided = 1'b1;
      req.meta.col    = job.col;
      req.meta.row    = job.row;
      req.meta.last   = 1'b1;
      req.meta.eof    = 1'b1;
    end
  end

  upsxy_slope_pipe u_pipe (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (|pend),
    .req_ready     (req_ready),
    .req           (req),
    .inv_spacing_x (inv_spacing_x),
    .inv_spacing_y (inv_spacing_y),
    .slope_valid   (slope_valid),
    .slope_stall   (slope_stall),
    .slope_x       (slope_x),
    .slope_y       (slope_y),
    .cell_column   (cell_column),
    .cell_row      (cell_row),
    .last_of_item  (last_of_item),
    .end_of_frame  (end_of_frame)
  );

endmodule

@@ rtl/core/upsxy_slope_pipe.sv @@
// Slope arithmetic pipeline: multiply, upwind select, round and saturate.
// Depends on upsxy_pkg; owns the output register of the block.
module upsxy_slope_pipe (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_ready,
  input  upsxy_pkg::slope_req_t                  req,
  input  logic [upsxy_pkg::INV_BITS-1:0]         inv_spacing_x,
  input  logic [upsxy_pkg::INV_BITS-1:0]         inv_spacing_y,
  output logic                                   slope_valid,
  input  logic                                   slope_stall,
  output logic signed [upsxy_pkg::SLOPE_BITS-1:0] slope_x,
  output logic signed [upsxy_pkg::SLOPE_BITS-1:0] slope_y,
  output logic [upsxy_pkg::COL_BITS-1:0]         cell_column,
  output logic [upsxy_pkg::ROW_BITS-1:0]         cell_row,
  output logic                                   last_of_item,
  output logic                                   end_of_frame
);
  import upsxy_pkg::*;

  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

  function automatic logic signed [PROD_BITS-1:0] mul(
    input logic signed [DIFF_BITS-1:0] d,
    input logic signed [INV_BITS:0]    k
  );
    logic signed [PROD_BITS-1:0] de;
    logic signed [PROD_BITS-1:0] ke;
    de = PROD_BITS'(d);
    ke = PROD_BITS'(k);
    return de * ke;
  endfunction

  // Local maximum: larger magnitude wins, tie to s2. Minimum or zero: zero.
  function automatic logic signed [PROD_BITS-1:0] choose(
    input logic signed [PROD_BITS-1:0] s1,
    input logic signed [PROD_BITS-1:0] s2,
    input logic                        one_sided
  );
    logic signed [PROD_BITS:0] sum;
    logic pos1, neg1, pos2, neg2, sum_pos;
    sum     = (PROD_BITS + 1)'(s1) + (PROD_BITS + 1)'(s2);
    neg1    = s1[PROD_BITS-1];
    pos1    = !neg1 && (|s1);
    neg2    = s2[PROD_BITS-1];
    pos2    = !neg2 && (|s2);
    sum_pos = !sum[PROD_BITS] && (|sum);
    priority if (one_sided)     return s2;
    else if (pos1 && neg2)      return sum_pos ? s1 : s2;
    else if (neg1 && neg2)      return s1;
    else if (pos1 && pos2)      return s2;
    else                        return '0;
  endfunction

  function automatic logic signed [SLOPE_BITS-1:0] round_sat(
    input logic signed [PROD_BITS-1:0] p
  );
    logic signed [ROUND_BITS-1:0] t;
    logic signed [Q_BITS-1:0]     q;
    logic signed [EXT_BITS-1:0]   qe;
    logic [EXT_BITS-SLOPE_BITS:0] hi;
    t  = ROUND_BITS'(p) + ROUND_BITS'(ROUND_HALF);
    q  = t[ROUND_BITS-1:FRAC_BITS];
    qe = EXT_BITS'(q);
    hi = qe[EXT_BITS-1:SLOPE_BITS-1];
    if ((&hi) || !(|hi)) return qe[SLOPE_BITS-1:0];
    else if (qe[EXT_BITS-1]) return {1'b1, {(SLOPE_BITS-1){1'b0}}};
    else return {1'b0, {(SLOPE_BITS-1){1'b1}}};
  endfunction

  logic signed [INV_BITS:0] inv_x_s;
  logic signed [INV_BITS:0] inv_y_s;
  assign inv_x_s = $signed({1'b0, inv_spacing_x});
  assign inv_y_s = $signed({1'b0, inv_spacing_y});

  logic       a_valid, b_valid, c_valid;
  logic       a_ready, b_ready, c_ready, d_ready;
  slope_req_t a_req;

  logic signed [PROD_BITS-1:0] b_x1, b_x2, b_y1, b_y2;
  logic                        b_os_x, b_os_y;
  meta_t                       b_meta;

  logic signed [PROD_BITS-1:0] c_x, c_y;
  meta_t                       c_meta;

  assign d_ready   = !slope_valid || !slope_stall;
  assign c_ready   = !c_valid || d_ready;
  assign b_ready   = !b_valid || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign req_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      c_valid     <= 1'b0;
      slope_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= req_valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
      if (d_ready) slope_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) a_req <= req;
    if (b_ready) begin
      b_x1   <= mul($signed(a_req.x.d1), inv_x_s);
      b_x2   <= mul($signed(a_req.x.d2), inv_x_s);
      b_y1   <= mul($signed(a_req.y.d1), inv_y_s);
      b_y2   <= mul($signed(a_req.y.d2), inv_y_s);
      b_os_x <= a_req.x.one_sided;
      b_os_y <= a_req.y.one_sided;
      b_meta <= a_req.meta;
    end
    if (c_ready) begin
      c_x    <= choose(b_x1, b_x2, b_os_x);
      c_y    <= choose(b_y1, b_y2, b_os_y);
      c_meta <= b_meta;
    end
    if (d_ready) begin
      slope_x      <= round_sat(c_x);
      slope_y      <= round_sat(c_y);
      cell_column  <= c_meta.col;
      cell_row     <= c_meta.row;
      last_of_item <= c_meta.last;
      end_of_frame <= c_meta.eof;
    end
  end

endmodule

@@ rtl/core/upsxy_checker.sv @@
// Port-level checks for the upwind slope stencil, bound to the top level.
// Depends on upwind_slope_xy_stencil_macros.svh and upsxy_pkg.
`include "upwind_slope_xy_stencil_macros.svh"

module upsxy_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   slope_valid,
  input logic                                   slope_stall,
  input logic signed [upsxy_pkg::SLOPE_BITS-1:0] slope_x,
  input logic signed [upsxy_pkg::SLOPE_BITS-1:0] slope_y,
  input logic [upsxy_pkg::COL_BITS-1:0]         cell_column,
  input logic [upsxy_pkg::ROW_BITS-1:0]         cell_row,
  input logic                                   last_of_item,
  input logic                                   end_of_frame
);
  import upsxy_pkg::*;

  logic [2*SLOPE_BITS+COL_BITS+ROW_BITS+1:0] out_bus;

  assign out_bus = {slope_x, slope_y, cell_column, cell_row, last_of_item, end_of_frame};

  // hold a stalled result
  `UPSXY_ASSERT_NEXT(a_out_hold, slope_valid && slope_stall, slope_valid && $stable(out_bus))

  // the frame's last cell is always the final result of its item
  `UPSXY_ASSERT_NOW(a_eof_last, slope_valid && end_of_frame, last_of_item)

  // the frame's last cell never sits on row or column zero
  `UPSXY_ASSERT_NOW(a_eof_corner, slope_valid && end_of_frame, cell_column != '0 && cell_row != '0)

  // reset drops any pending result
  `UPSXY_ASSERT_RESET(a_reset_idle, rst, !slope_valid)

endmodule

bind upwind_slope_xy_stencil upsxy_checker u_upsxy_checker (.*);

@@ tb/sv/tb_upwind_slope_xy_stencil.sv @@
`timescale 1ns / 100ps
// Self-checking bench for upwind_slope_xy_stencil: streams elevation frames and
// compares each result against an in-bench upwind slope predictor.
// Depends on upsxy_pkg and the stencil RTL only.
module tb_upwind_slope_xy_stencil;
  import upsxy_pkg::*;

  localparam int     DRAIN_CYCLES = 12;
  localparam int     HOLD_CYCLES  = 300;
  localparam longint CYCLE_LIMIT  = 500000;
  localparam longint SLOPE_MAX    = (longint'(1) << (SLOPE_BITS - 1)) - 1;
  localparam longint SLOPE_MIN    = -SLOPE_MAX - 1;

  typedef logic signed [ELEV_BITS-1:0] elev_t;

  typedef struct {
    logic signed [SLOPE_BITS-1:0] slope_x;
    logic signed [SLOPE_BITS-1:0] slope_y;
    logic [COL_BITS-1:0]          column;
    logic [ROW_BITS-1:0]          row;
    logic                         last;
    logic                         eof;
  } cell_slope_t;

  logic                          clk         = 1'b0;
  logic                          rst         = 1'b1;
  logic                          cfg_write   = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_index   = '0;
  logic [CFG_BITS-1:0]           cfg_data    = '0;
  logic                          elev_valid  = 1'b0;
  logic                          elev_stall;
  elev_t                         elevation   = '0;
  logic                          slope_valid;
  logic                          slope_stall = 1'b0;
  logic signed [SLOPE_BITS-1:0]  slope_x;
  logic signed [SLOPE_BITS-1:0]  slope_y;
  logic [COL_BITS-1:0]           cell_column;
  logic [ROW_BITS-1:0]           cell_row;
  logic                          last_of_item;
  logic                          end_of_frame;

  // Predictor state: two row stores, the one holding the previous row,
  // raster position and the last two samples of the current row.
  elev_t       terrain_rows [2][MAX_WIDTH];
  bit          recent_row = 1'b0;
  int unsigned next_col   = 0;
  int unsigned next_row   = 0;
  elev_t       trail [2]  = '{'0, '0};
  int unsigned grid_w_reg = MAX_WIDTH;
  int unsigned grid_h_reg = 1024;
  longint      inv_x_reg  = 65536;
  longint      inv_y_reg  = 65536;

  cell_slope_t pending_slopes [$];
  int          error_count   = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_request  = 1'b0;
  int          hold_left     = 0;
  longint      cycle_count   = 0;

  upwind_slope_xy_stencil dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL upwind_slope_xy_stencil");
      $finish;
    end
  end

  // Round to nearest (half up) out of Q.16, then saturate.
  function automatic longint round_sat(longint prod);
    longint q;
    q = (prod + 32768) >>> 16;
    if (q > SLOPE_MAX) q = SLOPE_MAX;
    if (q < SLOPE_MIN) q = SLOPE_MIN;
    return q;
  endfunction

  function automatic longint upwind_pick(longint lo, longint mid, longint hi, longint inv);
    longint back_d;
    longint fwd_d;
    back_d = (mid - lo) * inv;
    fwd_d  = (hi - mid) * inv;
    if (back_d > 0 && fwd_d < 0) return round_sat((back_d > -fwd_d) ? back_d : fwd_d);
    if (back_d < 0 && fwd_d < 0) return round_sat(back_d);
    if (back_d > 0 && fwd_d > 0) return round_sat(fwd_d);
    return 0;
  endfunction

  function automatic longint prev_at(int unsigned idx);
    return longint'(terrain_rows[recent_row][idx]);
  endfunction

  function automatic void queue_cell_slope(longint sx, longint sy, int unsigned col,
                                           int unsigned row, bit eof);
    cell_slope_t slot;
    slot.slope_x = SLOPE_BITS'(sx);
    slot.slope_y = SLOPE_BITS'(sy);
    slot.column  = COL_BITS'(col);
    slot.row     = ROW_BITS'(row);
    slot.last    = 1'b0;
    slot.eof     = eof;
    pending_slopes.push_back(slot);
  endfunction

  function automatic void predict_cell(elev_t sample);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int          first;
    longint      e;
    longint      mid;
    longint      p0;
    longint      sx;
    longint      sy;
    w = (grid_w_reg < 2) ? 2 : ((grid_w_reg > MAX_WIDTH) ? MAX_WIDTH : grid_w_reg);
    h = (grid_h_reg < 2) ? 2 : grid_h_reg;
    if (next_col >= w) next_col = 0;
    if (next_row >= h) next_row = 0;
    c = next_col;
    r = next_row;
    e = longint'(sample);
    first = pending_slopes.size();

    // cell one row up
    if (r >= 1) begin
      mid = prev_at(c);
      if (c == 0)
        sx = round_sat((prev_at(1) - mid) * inv_x_reg);
      else if (c == w - 1)
        sx = round_sat((mid - prev_at(c - 1)) * inv_x_reg);
      else
        sx = upwind_pick(prev_at(c - 1), mid, prev_at(c + 1), inv_x_reg);
      if (r == 1)
        sy = round_sat((e - mid) * inv_y_reg);
      else
        sy = upwind_pick(longint'(terrain_rows[!recent_row][c]), mid, e, inv_y_reg);
      queue_cell_slope(sx, sy, c, r - 1, 1'b0);
    end

    // last row flushes itself: cell to the left, and the row end
    if (r == h - 1) begin
      p0 = longint'(trail[0]);
      if (c >= 1) begin
        if (c == 1)
          sx = round_sat((e - p0) * inv_x_reg);
        else
          sx = upwind_pick(longint'(trail[1]), p0, e, inv_x_reg);
        sy = round_sat((p0 - prev_at(c - 1)) * inv_y_reg);
        queue_cell_slope(sx, sy, c - 1, r, 1'b0);
      end
      if (c == w - 1)
        queue_cell_slope(round_sat((e - p0) * inv_x_reg),
                         round_sat((e - prev_at(c)) * inv_y_reg), c, r, 1'b1);
    end

    if (pending_slopes.size() > first)
      pending_slopes[pending_slopes.size() - 1].last = 1'b1;

    terrain_rows[!recent_row][c] = sample;
    trail[1] = trail[0];
    trail[0] = sample;
    if (c == w - 1) begin
      next_col   = 0;
      recent_row = !recent_row;
      next_row   = (r == h - 1) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
  endfunction

  function automatic void apply_reg(cfg_reg_t idx, logic [CFG_BITS-1:0] value);
    case (idx)
      REG_GRID_WIDTH: begin
        grid_w_reg = 32'(value[GW_BITS-1:0]);
        next_col   = 0;
        next_row   = 0;
      end
      REG_GRID_HEIGHT: begin
        grid_h_reg = 32'(value[GH_BITS-1:0]);
        next_col   = 0;
        next_row   = 0;
      end
      REG_INV_SPACING_X: inv_x_reg = longint'(value[INV_BITS-1:0]);
      REG_INV_SPACING_Y: inv_y_reg = longint'(value[INV_BITS-1:0]);
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] spacing_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2, 3:    return CFG_BITS'($urandom_range(1, 'h3FFFF));
      default: return CFG_BITS'($urandom);
    endcase
  endfunction

  // Mostly small steps around a base so ties and sign cases show up often.
  function automatic elev_t terrain_sample(elev_t base);
    int delta;
    if ($urandom_range(3) == 0) return elev_t'($urandom);
    delta = $urandom_range(0, 8);
    return elev_t'(base + delta - 4);
  endfunction

  task automatic send_elev(elev_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      elev_valid <= 1'b0;
      @(posedge clk);
    end
    elev_valid <= 1'b1;
    elevation  <= value;
    do begin
      @(posedge clk);
    end while (elev_stall);
    predict_cell(value);
  endtask

  // Drain, let in-flight row-0 items settle, then write all four registers.
  task automatic configure(logic [CFG_BITS-1:0] width_word, logic [CFG_BITS-1:0] height_word,
                           logic [CFG_BITS-1:0] inv_x_word, logic [CFG_BITS-1:0] inv_y_word);
    logic [CFG_BITS-1:0] words [4];
    cfg_reg_t            idx;
    elev_valid <= 1'b0;
    while (pending_slopes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    words = '{width_word, height_word, inv_x_word, inv_y_word};
    idx = REG_GRID_WIDTH;
    repeat (4) begin
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= words[idx];
      @(posedge clk);
      apply_reg(idx, words[idx]);
      idx = idx.next();
    end
    cfg_write <= 1'b0;
  endtask

  task automatic test_directed_cases();
    int peaks [9] = '{8388607, -8388608, 0, -8388608, 8388607, -1, 1, -8388608, 8388607};
    int cases [15] = '{0, 5, 3, 7, 7,  0, 10, 0, -5, -9,  1, 2, 3, 2, 2};
    // full-scale steps: x saturates both ways, zero y spacing
    configure(24'd3, 24'd3, '1, '0);
    foreach (peaks[i]) send_elev(elev_t'(peaks[i]));
    // unit spacing: peak with larger side, peak tie, pit, both down, both up, flat
    configure(24'd5, 24'd3, 24'h010000, 24'h010000);
    foreach (cases[i]) send_elev(elev_t'(cases[i]));
  endtask

  task automatic test_geometry_extremes();
    elev_t base;
    base = elev_t'($urandom);
    // junk above both fields; height 1 is used as 2
    configure(24'hFFF804, 24'hFF0001, spacing_word(), spacing_word());
    repeat (8) send_elev(terrain_sample(base));
    // full-scale x spacing; tallest grid, cut off after three rows
    configure(24'h000003, 24'h00FFFF, '1, 24'h000001);
    repeat (9) send_elev(terrain_sample(base));
    // restart mid-frame; width 0 and height 0 are used as 2
    configure('0, '0, 24'h010000, 24'h008000);
    repeat (8) send_elev(terrain_sample(base));
    configure(24'h000001, 24'h00FFFF, spacing_word(), spacing_word());
    repeat (6) send_elev(terrain_sample(base));
  endtask

  task automatic test_backpressure();
    elev_t base;
    base = elev_t'($urandom);
    configure(24'd6, 24'd4, spacing_word(), spacing_word());
    send_idle_pct = 0;
    hold_request  = 1'b1;
    repeat (24) send_elev(terrain_sample(base));
  endtask

  task automatic test_random_frames(int unsigned item_budget);
    int unsigned         sent;
    int unsigned         w_used;
    int unsigned         h_used;
    int unsigned         count;
    logic [CFG_BITS-1:0] width_word;
    logic [CFG_BITS-1:0] height_word;
    elev_t               base;
    sent = 0;
    while (sent < item_budget) begin
      width_word  = CFG_BITS'($urandom_range(2, 8));
      height_word = CFG_BITS'($urandom_range(2, 5));
      case ($urandom_range(7))
        0: width_word = CFG_BITS'($urandom_range(0, 1));
        1: height_word = CFG_BITS'($urandom_range(0, 1));
        2: begin
          width_word  = CFG_BITS'($urandom_range(9, 40));
          height_word = CFG_BITS'(2);
        end
        default: ;
      endcase
      // bits above each field are dropped by the block
      width_word[CFG_BITS-1:GW_BITS]  = (CFG_BITS - GW_BITS)'($urandom);
      height_word[CFG_BITS-1:GH_BITS] = (CFG_BITS - GH_BITS)'($urandom);
      w_used = (width_word[GW_BITS-1:0] < 2) ? 2 : 32'(width_word[GW_BITS-1:0]);
      h_used = (height_word[GH_BITS-1:0] < 2) ? 2 : 32'(height_word[GH_BITS-1:0]);
      configure(width_word, height_word, spacing_word(), spacing_word());
      count = w_used * h_used;
      case ($urandom_range(5))
        0: count = $urandom_range(1, count - 1);
        1: count = count + w_used;
        default: ;
      endcase
      if (count > item_budget - sent) count = item_budget - sent;
      base = elev_t'($urandom);
      repeat (count) send_elev(terrain_sample(base));
      sent += count;
    end
  endtask

  // Receiver: random stall, or a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      slope_stall <= 1'b1;
    end else begin
      slope_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [SLOPE_BITS-1:0] want,
                                      logic [SLOPE_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    cell_slope_t want;
    if (!rst && slope_valid === 1'b1 && slope_stall === 1'b0) begin
      if (pending_slopes.size() == 0) begin
        $display("%0t: unexpected result at col %0d row %0d", $time, cell_column, cell_row);
        error_count++;
      end else begin
        want = pending_slopes.pop_front();
        check_field("slope_x", want.slope_x, slope_x);
        check_field("slope_y", want.slope_y, slope_y);
        check_field("cell_column", SLOPE_BITS'(want.column), SLOPE_BITS'(cell_column));
        check_field("cell_row", SLOPE_BITS'(want.row), SLOPE_BITS'(cell_row));
        check_field("last_of_item", SLOPE_BITS'(want.last), SLOPE_BITS'(last_of_item));
        check_field("end_of_frame", SLOPE_BITS'(want.eof), SLOPE_BITS'(end_of_frame));
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 14;
    recv_idle_pct = 47;
    test_directed_cases();
    test_geometry_extremes();
    test_backpressure();
    send_idle_pct = 14;
    recv_idle_pct = 47;
    test_random_frames(47);
    send_idle_pct = 47;
    recv_idle_pct = 14;
    test_random_frames(47);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(47);
    elev_valid <= 1'b0;
    while (pending_slopes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("PASS upwind_slope_xy_stencil");
    else
      $display("FAIL upwind_slope_xy_stencil");
    $finish;
  end

endmodule
